/* design/wbps_pkg.sv */
// shared types and constants of the wildcard byte pattern scanner
`default_nettype none
package wbps_pkg;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int PAT_BYTES   = 16;
	localparam int LEN_W       = 5;
	localparam int COUNT_W     = 32;

	// result limit value that disables the limit
	localparam logic [COUNT_W-1:0] NO_LIMIT = '0;

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PAT_LOW   = 3'd0,
		CFG_PAT_HIGH  = 3'd1,
		CFG_CARE      = 3'd2,
		CFG_LENGTH    = 3'd3,
		CFG_RANGE_MIN = 3'd4,
		CFG_RANGE_MAX = 3'd5,
		CFG_LIMIT     = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_MATCH     = 2'd0,
		KIND_END_FOUND = 2'd1,
		KIND_END_EMPTY = 2'd2
	} result_kind_t;

	// window control from the input side
	typedef struct packed {
		logic shift;
		logic restart;
		logic flush;
	} win_ctrl_t;

endpackage
`default_nettype wire

/* design/wbps_window.sv */
// byte shift window with fill count and masked parallel pattern compare
`default_nettype none
module wbps_window
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire win_ctrl_t                ctrl,
	input  wire byte_t                    byte_value,
	input  wire byte_t [PAT_BYTES-1:0]    pattern,
	input  wire logic  [PAT_BYTES-1:0]    care_mask,
	input  wire logic  [LEN_W-1:0]        len,
	output logic                          full,
	output logic                          match
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	byte_t [MAX_PATTERN-1:0] window_q;
	logic  [FILL_W-1:0]      fill_q;
	logic  [FILL_W-1:0]      fill_base;

	// newest byte at index 0
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			window_q[0] <= byte_value;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	assign fill_base = ctrl.restart ? '0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.flush) begin
			fill_q <= '0;
		end else if (ctrl.shift) begin
			if (fill_base == FILL_W'(MAX_PATTERN)) begin
				fill_q <= fill_base;
			end else begin
				fill_q <= fill_base + FILL_W'(1);
			end
		end
	end

	assign full = (LEN_W'(fill_q) >= len);

	// window index k holds pattern byte len-1-k
	always_comb begin
		logic [LEN_W-1:0] j;
		match = 1'b1;
		j     = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			j = len - LEN_W'(k) - LEN_W'(1);
			if (LEN_W'(k) < len && care_mask[j[3:0]] && window_q[k] != pattern[j[3:0]]) begin
				match = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* design/wildcard_byte_pattern_scanner.sv */
// Wildcard byte pattern scanner.
// Input channel (in_valid/in_ready) carries one word per memory byte with its
// address and a region start flag, or an end-of-scan word (req_type high).
// Bytes shift into a window of up to MAX_PATTERN bytes, emptied at each region
// start; once it holds pattern_length bytes it is compared with the pattern,
// wildcard bytes being those whose care_mask bit is clear. Matches whose start
// address lies in [range_min, range_max] are reported on the output channel
// (out_valid/out_ready); a start above range_max or reaching result_limit
// stops matching until end of scan, which reports whether anything was found.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, since the block itself does not enforce it.
// Throughput: one word per cycle while the output is not stalled. An accepted
// word waits in an input stage, then its result goes to the output register.
// Words that cause no result are dropped at the output register stage.
// When the receiver stalls, the output register holds its word and the input
// stage can still take one more word; in_ready then falls until it drains.
// Reset clears the window fill, match count, stop flag and both valid flags,
// and restores register defaults (length 1, full address range, no limit).
`default_nettype none
module wildcard_byte_pattern_scanner
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 16,
	parameter int ADDR_BITS   = 48
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   req_type,
	input  wire logic [7:0]             byte_value,
	input  wire logic [ADDR_BITS-1:0]   byte_address,
	input  wire logic                   region_start,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [1:0]                  result_kind,
	output logic [ADDR_BITS-1:0]        match_address,
	output logic                        limit_reached
);

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [PAT_BYTES-1:0]  care_q;
	logic [LEN_W-1:0]      length_q;
	logic [ADDR_BITS-1:0]  range_min_q;
	logic [ADDR_BITS-1:0]  range_max_q;
	logic [COUNT_W-1:0]    limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q   <= '0;
			pat_high_q  <= '0;
			care_q      <= '0;
			length_q    <= LEN_W'(1);
			range_min_q <= '0;
			range_max_q <= '1;
			limit_q     <= NO_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PAT_LOW:   pat_low_q   <= cfg_data;
				CFG_PAT_HIGH:  pat_high_q  <= cfg_data;
				CFG_CARE:      care_q      <= cfg_data[PAT_BYTES-1:0];
				CFG_LENGTH:    length_q    <= cfg_data[LEN_W-1:0];
				CFG_RANGE_MIN: range_min_q <= cfg_data[ADDR_BITS-1:0];
				CFG_RANGE_MAX: range_max_q <= cfg_data[ADDR_BITS-1:0];
				CFG_LIMIT:     limit_q     <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	byte_t [PAT_BYTES-1:0] pattern;
	logic  [LEN_W-1:0]     len;

	always_comb begin
		for (int j = 0; j < PAT_BYTES / 2; j++) begin
			pattern[j]                 = pat_low_q[8*j +: 8];
			pattern[j + PAT_BYTES / 2] = pat_high_q[8*j +: 8];
		end
	end

	// effective length: zero acts as one, clamp to window depth
	always_comb begin
		priority if (length_q == '0) begin
			len = LEN_W'(1);
		end else if (length_q > LEN_W'(MAX_PATTERN)) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = length_q;
		end
	end

	// input stage
	logic                 valid_s1;
	logic                 end_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 in_accept;
	logic                 adv;

	assign adv       = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			end_s1  <= req_type;
			addr_s1 <= byte_address;
		end
	end

	// window is updated on acceptance, so it matches the word in the input stage
	win_ctrl_t win_ctrl;
	logic      win_full;
	logic      win_match;

	assign win_ctrl.shift   = in_accept && !req_type;
	assign win_ctrl.restart = region_start;
	assign win_ctrl.flush   = in_accept && req_type;

	wbps_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.byte_value(byte_value),
		.pattern   (pattern),
		.care_mask (care_q),
		.len       (len),
		.full      (win_full),
		.match     (win_match)
	);

	// scan state and result decision
	logic [COUNT_W-1:0]   match_count_q;
	logic                 stopped_q;
	logic [ADDR_BITS-1:0] start_addr;
	logic                 cand;
	logic                 below_min;
	logic                 above_max;
	logic                 hit;
	logic [COUNT_W-1:0]   count_inc;
	logic                 limit_hit;
	logic                 has_result;

	assign start_addr = addr_s1 - ADDR_BITS'(len - LEN_W'(1));
	assign cand       = !end_s1 && !stopped_q && win_full;
	assign below_min  = start_addr < range_min_q;
	assign above_max  = start_addr > range_max_q;
	assign hit        = cand && !below_min && !above_max && win_match;
	assign count_inc  = (match_count_q == '1) ? match_count_q : match_count_q + COUNT_W'(1);
	assign limit_hit  = (limit_q != NO_LIMIT) && (count_inc == limit_q);
	assign has_result = end_s1 || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q <= '0;
			stopped_q     <= 1'b0;
		end else if (adv) begin
			if (end_s1) begin
				match_count_q <= '0;
				stopped_q     <= 1'b0;
			end else if (hit) begin
				match_count_q <= count_inc;
				if (limit_hit) begin
					stopped_q <= 1'b1;
				end
			end else if (cand && !below_min && above_max) begin
				stopped_q <= 1'b1;
			end
		end
	end

	// output register
	logic [1:0]           kind_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic                 at_limit_q;
	logic                 load_out;

	assign load_out = adv && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (end_s1) begin
				kind_q     <= (match_count_q != '0) ? KIND_END_FOUND : KIND_END_EMPTY;
				addr_q     <= '0;
				at_limit_q <= 1'b0;
			end else begin
				kind_q     <= KIND_MATCH;
				addr_q     <= start_addr;
				at_limit_q <= limit_hit;
			end
		end
	end

	assign result_kind   = kind_q;
	assign match_address = addr_q;
	assign limit_reached = at_limit_q;

	// checks
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> match_count_q == '0 && !stopped_q)
		else $error("end of scan did not clear scan state");

	a_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && !end_s1 && limit_hit |=> stopped_q)
		else $error("result limit did not stop the scan");

	a_end_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_MATCH |-> match_address == '0 && !limit_reached)
		else $error("end of scan word carries match data");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without a blocked output");

endmodule
`default_nettype wire

/* tb/wbps_checker.sv */
// predicts and checks the result words of the wildcard byte pattern scanner
`timescale 1ns / 1ps
module wbps_checker
	import wbps_pkg::*;
#(
	parameter int ADDR_BITS = 48
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire logic                   end_of_scan,
	input  wire logic [7:0]             byte_value,
	input  wire logic [ADDR_BITS-1:0]   byte_address,
	input  wire logic                   region_start,
	input  wire logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire logic [1:0]             result_kind,
	input  wire logic [ADDR_BITS-1:0]   match_address,
	input  wire logic                   limit_reached,
	output int unsigned                 mismatches,
	output int unsigned                 results_due
);

	typedef struct packed {
		result_kind_t         kind;
		logic [ADDR_BITS-1:0] addr;
		logic                 at_limit;
	} scan_result_t;

	// configuration as last written
	logic [63:0]          pat_low;
	logic [63:0]          pat_high;
	logic [15:0]          care;
	logic [LEN_W-1:0]     pat_len;
	logic [ADDR_BITS-1:0] lo_addr;
	logic [ADDR_BITS-1:0] hi_addr;
	logic [COUNT_W-1:0]   hit_limit;

	// scan state
	byte_t                window [PAT_BYTES];
	int unsigned          fill;
	logic [COUNT_W-1:0]   hit_count;
	logic                 stopped;

	scan_result_t         pending_results_q[$];

	task automatic report(input string msg);
		mismatches++;
		// keep the log bounded if the block is badly broken
		if (mismatches <= 100)
			$display("%0t ns: %s", $time, msg);
	endtask

	function automatic byte_t pattern_at(input int unsigned j);
		logic [127:0] all;
		all = {pat_high, pat_low};
		return all[8*j +: 8];
	endfunction

	// newest byte sits in window[0], so pattern byte j lines up with window[n-1-j]
	function automatic logic window_hits(input int unsigned n);
		int unsigned j;
		for (j = 0; j < n; j++)
			if (care[j] && window[n-1-j] != pattern_at(j))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic scan_word(input logic is_end, input byte_t val,
			input logic [ADDR_BITS-1:0] addr, input logic restart);
		int unsigned n;
		int i;
		logic [ADDR_BITS-1:0] start;
		scan_result_t r;
		r.addr = '0;
		r.at_limit = 1'b0;
		if (is_end) begin
			if (hit_count != 0)
				r.kind = KIND_END_FOUND;
			else
				r.kind = KIND_END_EMPTY;
			pending_results_q.insert(pending_results_q.size(), r);
			hit_count = '0;
			stopped = 1'b0;
			fill = 0;
			return;
		end
		if (restart)
			fill = 0;
		for (i = PAT_BYTES - 1; i > 0; i--)
			window[i] = window[i-1];
		window[0] = val;
		if (fill < PAT_BYTES)
			fill++;
		if (pat_len == 0)
			n = 1;
		else if (pat_len > PAT_BYTES)
			n = PAT_BYTES;
		else
			n = pat_len;
		if (stopped || fill < n)
			return;
		start = addr - ADDR_BITS'(n - 1);
		if (start < lo_addr)
			return;
		if (start > hi_addr) begin
			stopped = 1'b1;
			return;
		end
		if (!window_hits(n))
			return;
		if (hit_count != '1)
			hit_count++;
		r.kind = KIND_MATCH;
		r.addr = start;
		if (hit_limit != NO_LIMIT && hit_count == hit_limit) begin
			r.at_limit = 1'b1;
			stopped = 1'b1;
		end
		pending_results_q.insert(pending_results_q.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		int i;
		if (!arst_n) begin
			pat_low = '0;
			pat_high = '0;
			care = '0;
			pat_len = LEN_W'(1);
			lo_addr = '0;
			hi_addr = '1;
			hit_limit = NO_LIMIT;
			for (i = 0; i < PAT_BYTES; i++)
				window[i] = '0;
			fill = 0;
			hit_count = '0;
			stopped = 1'b0;
			pending_results_q.delete();
			mismatches = 0;
			results_due <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index_t'(cfg_index))
					CFG_PAT_LOW:   pat_low = cfg_data;
					CFG_PAT_HIGH:  pat_high = cfg_data;
					CFG_CARE:      care = cfg_data[15:0];
					CFG_LENGTH:    pat_len = cfg_data[LEN_W-1:0];
					CFG_RANGE_MIN: lo_addr = cfg_data[ADDR_BITS-1:0];
					CFG_RANGE_MAX: hi_addr = cfg_data[ADDR_BITS-1:0];
					CFG_LIMIT:     hit_limit = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				scan_word(end_of_scan, byte_value, byte_address, region_start);
			if (out_valid && out_ready) begin
				if (pending_results_q.size() == 0) begin
					report($sformatf("result word kind %0d addr %0h with nothing expected",
						result_kind, match_address));
				end else begin
					want = pending_results_q.pop_front();
					if (result_kind !== want.kind)
						report($sformatf("result_kind %0d, expected %0d",
							result_kind, want.kind));
					if (match_address !== want.addr)
						report($sformatf("match_address %0h, expected %0h",
							match_address, want.addr));
					if (limit_reached !== want.at_limit)
						report($sformatf("limit_reached %0b, expected %0b",
							limit_reached, want.at_limit));
				end
			end
			results_due <= pending_results_q.size();
		end
	end

endmodule

/* tb/tb.sv */
// stimulus, reset and verdict for the wildcard byte pattern scanner
`timescale 1ns / 1ps
module tb;
	import wbps_pkg::*;

	localparam int ADDR_BITS    = 48;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_WORDS = 1200;
	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_END    = 1'b1;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   req_type = REQ_BYTE;
	logic [7:0]             byte_value = '0;
	logic [ADDR_BITS-1:0]   byte_address = '0;
	logic                   region_start = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             result_kind;
	logic [ADDR_BITS-1:0]   match_address;
	logic                   limit_reached;

	int unsigned mismatches;
	int unsigned results_due;
	int unsigned quiet = 0;
	logic        tx_gaps = 1'b1;
	logic        rx_gaps = 1'b1;
	logic        hold_req = 1'b0;

	wildcard_byte_pattern_scanner #(
		.MAX_PATTERN(PAT_BYTES),
		.ADDR_BITS(ADDR_BITS)
	) uut (.*);

	wbps_checker #(.ADDR_BITS(ADDR_BITS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.end_of_scan(req_type),
		.byte_value(byte_value),
		.byte_address(byte_address),
		.region_start(region_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.match_address(match_address),
		.limit_reached(limit_reached),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// nothing accepted on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(rx_gaps && $urandom_range(0, 99) < 12);
			end
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] low, input logic [63:0] high,
			input logic [15:0] care, input logic [4:0] len,
			input logic [ADDR_BITS-1:0] rmin, input logic [ADDR_BITS-1:0] rmax,
			input logic [31:0] lim);
		write_reg(CFG_PAT_LOW, low);
		write_reg(CFG_PAT_HIGH, high);
		write_reg(CFG_CARE, 64'(care));
		write_reg(CFG_LENGTH, 64'(len));
		write_reg(CFG_RANGE_MIN, 64'(rmin));
		write_reg(CFG_RANGE_MAX, 64'(rmax));
		write_reg(CFG_LIMIT, 64'(lim));
		cfg_write <= 1'b0;
	endtask

	task automatic send_word(input logic req, input byte_t val,
			input logic [ADDR_BITS-1:0] addr, input logic rs);
		while (tx_gaps && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		byte_value <= val;
		byte_address <= addr;
		region_start <= rs;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait until every predicted word is out and the pipeline has emptied
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (6) @(posedge clk);
	endtask

	// random settings, then regions of bytes with the pattern planted at random
	task automatic random_phase(input int unsigned words);
		logic [ADDR_BITS-1:0] base, addr, rmin, rmax;
		logic [63:0]          low, high;
		logic [127:0]         pat;
		logic [15:0]          care;
		logic [4:0]           len;
		logic [31:0]          lim;
		byte_t                val;
		logic                 rs;
		int unsigned          n, sent, pos, run, r;
		low = {$urandom, $urandom};
		high = {$urandom, $urandom};
		pat = {high, low};
		r = $urandom_range(0, 9);
		care = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
		r = $urandom_range(0, 9);
		len = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 :
			(r == 2) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1, 8));
		n = (len == 0) ? 1 : (len > PAT_BYTES) ? PAT_BYTES : len;
		if ($urandom_range(0, 9) == 0)
			base = '1 - ADDR_BITS'($urandom_range(0, 200));
		else
			base = ADDR_BITS'({$urandom, $urandom});
		r = $urandom_range(0, 5);
		if (r == 0) begin
			rmin = '0;
			rmax = '1;
		end else if (r == 1) begin
			// empty range: the first candidate at or above the minimum stops the scan
			rmin = base + ADDR_BITS'($urandom_range(50, 500));
			rmax = rmin - ADDR_BITS'($urandom_range(1, 100));
		end else begin
			rmin = base + ADDR_BITS'($urandom_range(0, 200));
			rmax = rmin + ADDR_BITS'($urandom_range(0, 1500));
		end
		r = $urandom_range(0, 7);
		lim = (r < 4) ? 32'd0 : (r == 4) ? 32'd1 : (r == 5) ? 32'hFFFF_FFFF :
			32'($urandom_range(2, 10));
		configure(low, high, care, len, rmin, rmax, lim);

		addr = base;
		rs = 1'b1;
		pos = n;
		run = $urandom_range(1, 40);
		for (sent = 1; sent < words; sent++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				// end of scan mid-stream, ignored fields random
				send_word(REQ_END, byte_t'($urandom), ADDR_BITS'({$urandom, $urandom}),
					1'($urandom));
				continue;
			end
			if (r < 6) begin
				// broken sequence: address jump and a random region flag
				addr = ADDR_BITS'({$urandom, $urandom});
				rs = 1'($urandom);
			end
			if (run == 0) begin
				rs = 1'b1;
				run = $urandom_range(1, 40);
				addr += ADDR_BITS'($urandom_range(0, 20));
				pos = n;
			end
			if (pos >= n && $urandom_range(0, 99) < 15)
				pos = 0;
			if (pos < n) begin
				val = care[pos] ? pat[8*pos +: 8] : byte_t'($urandom);
				pos++;
			end else begin
				val = byte_t'($urandom);
			end
			send_word(REQ_BYTE, val, addr, rs);
			rs = 1'b0;
			addr++;
			run--;
		end
		send_word(REQ_END, byte_t'($urandom), ADDR_BITS'({$urandom, $urandom}),
			1'($urandom));
	endtask

	initial begin
		int unsigned rand_sent, phase, chunk;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// four byte pattern with byte 2 a wildcard
		configure(64'h0000_0000_4433_2211, 64'h0, 16'h000B, 5'd4, '0, '1, 32'd0);
		// match whose start wraps below address zero
		send_word(REQ_BYTE, 8'h11, 48'hFFFF_FFFF_FFFE, 1'b1);
		send_word(REQ_BYTE, 8'h22, 48'hFFFF_FFFF_FFFF, 1'b0);
		send_word(REQ_BYTE, 8'h99, 48'h0000_0000_0000, 1'b0);
		send_word(REQ_BYTE, 8'h44, 48'h0000_0000_0001, 1'b0);
		send_word(REQ_END, 8'hFF, '1, 1'b1);
		send_word(REQ_END, 8'h00, '0, 1'b0);
		// region start in mid-pattern must empty the window
		send_word(REQ_BYTE, 8'h11, 48'h8000_0000_0000, 1'b1);
		send_word(REQ_BYTE, 8'h22, 48'h8000_0000_0001, 1'b0);
		send_word(REQ_BYTE, 8'h33, 48'h8000_0000_0002, 1'b0);
		send_word(REQ_BYTE, 8'h44, 48'h0000_0000_1000, 1'b1);
		send_word(REQ_END, 8'h5A, 48'h1234_5678_9ABC, 1'b0);
		drain();

		// single byte pattern, narrow range: below min, inside, above max
		configure(64'h0000_0000_0000_00FF, '1, 16'h0001, 5'd1,
			48'h0000_0000_0100, 48'h0000_0000_0102, 32'd0);
		send_word(REQ_BYTE, 8'hFF, 48'h0000_0000_00FF, 1'b1);
		send_word(REQ_BYTE, 8'hFF, 48'h0000_0000_0100, 1'b0);
		send_word(REQ_BYTE, 8'h00, 48'h0000_0000_0101, 1'b0);
		send_word(REQ_BYTE, 8'hFF, 48'h0000_0000_0102, 1'b0);
		send_word(REQ_BYTE, 8'hFF, 48'h0000_0000_0103, 1'b0);
		send_word(REQ_BYTE, 8'hFF, 48'h0000_0000_0104, 1'b0);
		send_word(REQ_END, 8'h00, '0, 1'b0);
		drain();

		// zero length acts as one, all wildcards, limit of two
		configure(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 16'h0000, 5'd0,
			'0, '1, 32'd2);
		send_word(REQ_BYTE, 8'h01, 48'h0000_0000_0000, 1'b1);
		send_word(REQ_BYTE, 8'h80, 48'h0000_0000_0001, 1'b0);
		send_word(REQ_BYTE, 8'h7F, 48'h0000_0000_0002, 1'b0);
		send_word(REQ_END, 8'h00, '0, 1'b0);

		rand_sent = 0;
		phase = 0;
		while (rand_sent < RANDOM_WORDS) begin
			drain();
			tx_gaps = (phase != 2);
			rx_gaps = (phase != 2);
			// receiver holds off while words keep coming in
			if (phase == 1)
				hold_req = 1'b1;
			chunk = $urandom_range(60, 140);
			random_phase(chunk);
			rand_sent += chunk;
			phase++;
		end
		drain();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/wbps_pkg.sv
design/wbps_window.sv
design/wildcard_byte_pattern_scanner.sv
tb/wbps_checker.sv
tb/tb.sv
